[design/nearest_palette_color_search_assert.svh]
// ----------------------------------------------------------------------------
// Nearest palette colour search: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NPCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define NPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define NPCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define NPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/npcs_pkg.sv]
// ----------------------------------------------------------------------------
// Nearest palette colour search package
// Sizes, command codes, beat types and controller states.
// ----------------------------------------------------------------------------
package npcs_pkg;

    localparam int PALETTE_SIZE = 256;
    localparam int ADDR_W       = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int COL_W        = 8;
    localparam int IDX_W        = 8;
    localparam int SQ_W         = 2 * COL_W;
    localparam int DIST_W       = 18;
    localparam int ENTRY_W      = 3 * COL_W;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic             command;
        logic [IDX_W-1:0] entry_index;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_cmd_in;

    typedef struct packed {
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_distance;
    } t_result;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

[design/nearest_palette_color_search.sv]
// ----------------------------------------------------------------------------
// Nearest palette colour search
// Palette store with a sequential nearest-entry scan over squared RGB distance.
// ----------------------------------------------------------------------------
// A beat with command 0 writes one palette entry and gives no result; busy
// stays low. A beat with command 1 starts a scan: every palette entry is
// read from the on-chip memory, one entry per cycle through its single read
// port, so a query holds busy high until the last entry has been compared.
// The result then appears on o_result, marked by o_valid high for a single
// cycle; the receiver cannot stall it, so capture it on that cycle. Ties go
// to the lowest index. After reset every entry reads as black (per-entry
// valid bits), so no clearing pass is needed and the block takes beats from
// the first cycle after reset.
// ----------------------------------------------------------------------------
`include "nearest_palette_color_search_assert.svh"

module nearest_palette_color_search (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  npcs_pkg::t_cmd_in i_cmd,
    output logic             busy,
    output logic             o_valid,
    output npcs_pkg::t_result o_result
);
    import npcs_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_SIZE - 1);

    // palette memory and per-entry valid bits
    logic [ENTRY_W-1:0]      mem [PALETTE_SIZE];
    logic [PALETTE_SIZE-1:0] r_entry_vld;

    t_state              r_state, n_state;
    logic                accept, wr_en, query_go, scan_end;

    // query colour
    logic [COL_W-1:0]    r_q_red, r_q_green, r_q_blue;

    // read issue
    logic                r_issue;
    logic [ADDR_W-1:0]   r_addr;

    // stage 1: read data
    logic                r_p1_vld;
    logic [ADDR_W-1:0]   r_p1_idx;
    logic [ENTRY_W-1:0]  r_rd_data;
    logic                r_rd_ok;
    logic [ENTRY_W-1:0]  p1_entry;
    logic [COL_W-1:0]    d_red, d_green, d_blue;

    // stage 2: squares
    logic                r_p2_vld;
    logic [ADDR_W-1:0]   r_p2_idx;
    logic [SQ_W-1:0]     r_sq_red, r_sq_green, r_sq_blue;
    logic [DIST_W-1:0]   p2_dist;

    // running best
    logic [DIST_W-1:0]   r_best_d, n_best_d;
    logic [ADDR_W-1:0]   r_best_i, n_best_i;

    logic                r_valid;
    t_result             r_result;

    assign accept   = start && !busy;
    // drop writes that land beyond the palette
    assign wr_en    = accept && (i_cmd.command == CMD_WRITE)
                      && ({1'b0, i_cmd.entry_index} < (IDX_W + 1)'(PALETTE_SIZE));
    assign query_go = accept && (i_cmd.command == CMD_QUERY);
    assign scan_end = r_p2_vld && (r_p2_idx == LAST_ADDR);

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (query_go) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                busy = 1'b1;
                if (scan_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Palette memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_cmd.entry_index[ADDR_W-1:0]] <= {i_cmd.red, i_cmd.green, i_cmd.blue};
        end
        r_rd_data <= mem[r_addr];
    end

    // valid bits: an entry never written reads as black
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (wr_en) begin
                r_entry_vld[i_cmd.entry_index[ADDR_W-1:0]] <= 1'b1;
            end
            r_rd_ok <= r_entry_vld[r_addr];
        end
    end

    // ------------------------------------------------------------------
    // Read issue and pipeline control
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= 1'b0;
            r_addr   <= '0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            if (query_go) begin
                r_issue <= 1'b1;
                r_addr  <= '0;
            end else if (r_issue) begin
                // stop issuing after the last entry, else advance
                if (r_addr == LAST_ADDR) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            r_p1_vld <= r_issue;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (query_go) begin
            r_q_red   <= i_cmd.red;
            r_q_green <= i_cmd.green;
            r_q_blue  <= i_cmd.blue;
        end
        r_p1_idx <= r_addr;
        r_p2_idx <= r_p1_idx;
    end

    // ------------------------------------------------------------------
    // Stage 1: absolute differences and squares
    // ------------------------------------------------------------------
    assign p1_entry = r_rd_ok ? r_rd_data : '0;

    always_comb begin
        logic [COL_W-1:0] e_red, e_green, e_blue;
        e_red   = p1_entry[ENTRY_W-1 -: COL_W];
        e_green = p1_entry[2*COL_W-1 -: COL_W];
        e_blue  = p1_entry[COL_W-1:0];
        d_red   = (r_q_red   >= e_red)   ? (r_q_red   - e_red)   : (e_red   - r_q_red);
        d_green = (r_q_green >= e_green) ? (r_q_green - e_green) : (e_green - r_q_green);
        d_blue  = (r_q_blue  >= e_blue)  ? (r_q_blue  - e_blue)  : (e_blue  - r_q_blue);
    end

    always_ff @(posedge i_clk) begin
        r_sq_red   <= SQ_W'(d_red)   * SQ_W'(d_red);
        r_sq_green <= SQ_W'(d_green) * SQ_W'(d_green);
        r_sq_blue  <= SQ_W'(d_blue)  * SQ_W'(d_blue);
    end

    // ------------------------------------------------------------------
    // Stage 2: sum and compare; strictly-less keeps the lowest index
    // ------------------------------------------------------------------
    assign p2_dist = DIST_W'(r_sq_red) + DIST_W'(r_sq_green) + DIST_W'(r_sq_blue);

    always_comb begin
        n_best_d = r_best_d;
        n_best_i = r_best_i;
        if ((r_p2_idx == '0) || (p2_dist < r_best_d)) begin
            n_best_d = p2_dist;
            n_best_i = r_p2_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p2_vld) begin
            r_best_d <= n_best_d;
            r_best_i <= n_best_i;
        end
        if (scan_end) begin
            r_result.best_index    <= IDX_W'(n_best_i);
            r_result.best_distance <= n_best_d;
        end
    end

    // result strobe: one cycle per query
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= scan_end;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `NPCS_ASSERT_NEXT(a_query_holds_busy, i_clk, i_rst_n, query_go, busy)
    `NPCS_ASSERT_IMPLY(a_result_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `NPCS_ASSERT_IMPLY(a_pipe_only_in_scan, i_clk, i_rst_n, r_issue || r_p1_vld || r_p2_vld, r_state == ST_SCAN)
    `NPCS_ASSERT_NEXT(a_write_no_result, i_clk, i_rst_n, accept && (i_cmd.command == CMD_WRITE), !o_valid)

endmodule
